// File: rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and functions of the threshold exposure accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package tea_pkg;
    localparam int MaxEntries = 1024;

    localparam logic [2:0] KIND_ABOVE  = 3'd0;
    localparam logic [2:0] KIND_BELOW  = 3'd1;
    localparam logic [2:0] KIND_EXCESS = 3'd2;
    localparam logic [2:0] KIND_SQUARE = 3'd3;
    localparam logic [2:0] KIND_MAX    = 3'd4;
    localparam logic [2:0] KIND_MIN    = 3'd5;

    localparam logic [2:0] REG_KIND      = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_INCLUSIVE = 3'd2;
    localparam logic [2:0] REG_BELOW     = 3'd3;
    localparam logic [2:0] REG_SCOPE     = 3'd4;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] threshold;
        logic        inclusive;
        logic        below;
        logic        scope;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [31:0] sample_value;
        logic        in_region;
        logic [31:0] sample_weight;
        logic [31:0] time_step;
        logic        last_in_step;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  entry_index;
        logic [63:0] entry_value;
        logic [15:0] selected_count;
        logic [10:0] updated_count;
        logic        step_done;
        logic [31:0] step_total;
        logic [63:0] elapsed_total;
        logic        count_error;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic mul_d;
        logic finish;
    } cmd_t;

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [31:0] b);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [64:0] s;
        lo = {32'd0, a[31:0]} * {32'd0, b};
        hi = {32'd0, a[63:32]} * {32'd0, b};
        s  = {1'b0, hi[47:0], 16'd0} + {17'd0, lo[63:16]};
        if (hi[63:48] != 16'd0 || s[64])
            return '1;
        return s[63:0];
    endfunction

    function automatic logic [63:0] addsat_signed(input logic [63:0] old,
                                                  input logic [63:0] inc);
        if (!old[63] && inc > (64'h7FFF_FFFF_FFFF_FFFF - old))
            return 64'h7FFF_FFFF_FFFF_FFFF;
        return old + inc;
    endfunction

    function automatic logic [63:0] start_value(input logic [2:0] kind);
        if (kind == KIND_MAX) return 64'h8000_0000_0000_0000;
        if (kind == KIND_MIN) return 64'h7FFF_FFFF_FFFF_FFFF;
        return 64'd0;
    endfunction

    function automatic logic [63:0] pick_extreme(input logic [2:0] kind,
                                                 input logic [63:0] old,
                                                 input logic [63:0] nv);
        if (kind == KIND_MAX) return ($signed(nv) > $signed(old)) ? nv : old;
        if (kind == KIND_MIN) return ($signed(old) > $signed(nv)) ? nv : old;
        return old;
    endfunction
endpackage
`default_nettype wire

// File: rtl/tea_if.sv
// ----------------------------------------------------------------------------
// tea_in_if / tea_out_if
// Valid/ready channels of the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
interface tea_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] sample_value;
    logic        in_region;
    logic [31:0] sample_weight;
    logic [31:0] time_step;
    logic        last_in_step;
    modport source (output valid, command, sample_value, in_region, sample_weight,
                    time_step, last_in_step, input ready);
    modport sink (input valid, command, sample_value, in_region, sample_weight,
                  time_step, last_in_step, output ready);
endinterface

interface tea_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  entry_index;
    logic [63:0] entry_value;
    logic [15:0] selected_count;
    logic [10:0] updated_count;
    logic        step_done;
    logic [31:0] step_total;
    logic [63:0] elapsed_total;
    logic        count_error;
    modport source (output valid, entry_index, entry_value, selected_count,
                    updated_count, step_done, step_total, elapsed_total, count_error,
                    input ready);
    modport sink (input valid, entry_index, entry_value, selected_count,
                  updated_count, step_done, step_total, elapsed_total, count_error,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/threshold_exposure_accumulator_unit.sv
// A new item is taken only in the idle state, once the sequencer has gone
// through load, four multiply steps and the finish step with the entry store
// read-modify-write, and only while the result register is free to take it.
// Reset: rst_n clears all counters and flags at once; the entry store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// threshold_exposure_accumulator_unit
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module threshold_exposure_accumulator_unit #(
    parameter int MAX_ENTRIES = tea_pkg::MaxEntries
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    tea_in_if.sink           in_ch,
    tea_out_if.source        out_ch
);
    tea_pkg::cfg_t      cfg_reg;
    tea_pkg::cmd_t      cmd;
    tea_pkg::in_item_t  item;
    tea_pkg::out_item_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tea_pkg::REG_KIND:      cfg_reg.kind      <= cfg_data[2:0];
                tea_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_data;
                tea_pkg::REG_INCLUSIVE: cfg_reg.inclusive <= cfg_data[0];
                tea_pkg::REG_BELOW:     cfg_reg.below     <= cfg_data[0];
                tea_pkg::REG_SCOPE:     cfg_reg.scope     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign item.command       = in_ch.command;
    assign item.sample_value  = in_ch.sample_value;
    assign item.in_region     = in_ch.in_region;
    assign item.sample_weight = in_ch.sample_weight;
    assign item.time_step     = in_ch.time_step;
    assign item.last_in_step  = in_ch.last_in_step;

    tea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    tea_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .item   (item),
        .result (res)
    );

    assign out_ch.entry_index    = res.entry_index;
    assign out_ch.entry_value    = res.entry_value;
    assign out_ch.selected_count = res.selected_count;
    assign out_ch.updated_count  = res.updated_count;
    assign out_ch.step_done      = res.step_done;
    assign out_ch.step_total     = res.step_total;
    assign out_ch.elapsed_total  = res.elapsed_total;
    assign out_ch.count_error    = res.count_error;
endmodule
`default_nettype wire

// File: rtl/tea_ctrl.sv
// ----------------------------------------------------------------------------
// tea_ctrl
// Sequencer: load, four multiply steps, finish and hold the result.
// ----------------------------------------------------------------------------
`default_nettype none
module tea_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tea_pkg::cmd_t      cmd
);
    typedef enum logic [2:0] {S_IDLE, S_MA, S_MB, S_MC, S_MD, S_FIN} state_t;
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MB;
            end
            S_MB:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_MC;
            end
            S_MC:
            begin
                cmd.mul_c  = 1'b1;
                state_next = S_MD;
            end
            S_MD:
            begin
                cmd.mul_d  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/tea_dp.sv
// ----------------------------------------------------------------------------
// tea_dp
// Datapath: increment multiplies, entry store, step state and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module tea_dp #(
    parameter int MAX_ENTRIES = tea_pkg::MaxEntries
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tea_pkg::cmd_t     cmd,
    input  wire tea_pkg::cfg_t     cfg,
    input  wire tea_pkg::in_item_t item,
    output tea_pkg::out_item_t     result
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

    logic [63:0] store_mem [MAX_ENTRIES];

    tea_pkg::in_item_t item_reg;
    logic [CW-1:0] entry_count_reg, entry_cursor_reg;
    logic          store_ready_reg, have_extreme_reg, mismatch_reg;
    logic [63:0]   step_sum_reg, elapsed_reg;
    logic [31:0]   step_extreme_reg, step_counter_reg;
    logic [15:0]   tally_reg;
    logic [63:0]   acc_reg, rd_reg;
    logic [31:0]   e_reg;
    logic          above_reg, below_reg;
    tea_pkg::out_item_t result_reg;

    logic [AW-1:0] rd_addr;
    logic [32:0]   diff;
    logic          v_gt, v_eq;
    logic          is_ext;
    logic [CW-1:0] limit;
    logic          slot_ok;
    logic [63:0]   wacc;
    logic [64:0]   agg_sum;
    logic [31:0]   agg_ext;
    logic          agg_he;

    assign is_ext  = (cfg.kind == tea_pkg::KIND_MAX) || (cfg.kind == tea_pkg::KIND_MIN);
    assign limit   = store_ready_reg ? entry_count_reg : MaxCount;
    assign slot_ok = (entry_cursor_reg < limit) && (entry_cursor_reg < MaxCount);
    assign rd_addr = cfg.scope ? '0 : entry_cursor_reg[AW-1:0];
    assign result  = result_reg;

    always_comb
    begin
        diff = cfg.below
            ? {cfg.threshold[31], cfg.threshold} - {item_reg.sample_value[31],
                                                    item_reg.sample_value}
            : {item_reg.sample_value[31], item_reg.sample_value}
              - {cfg.threshold[31], cfg.threshold};
        v_gt = $signed(item_reg.sample_value) > $signed(cfg.threshold);
        v_eq = item_reg.sample_value == cfg.threshold;
    end

    always_comb
    begin
        wacc = acc_reg;
    end

    always_comb
    begin
        agg_sum = {1'b0, step_sum_reg};
        agg_ext = step_extreme_reg;
        agg_he  = have_extreme_reg;
        if (item_reg.in_region)
        begin
            agg_sum = {1'b0, step_sum_reg} + {1'b0, wacc};
            if (agg_sum[64])
                agg_sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            if (!agg_he || (cfg.kind == tea_pkg::KIND_MAX
                    ? $signed(item_reg.sample_value) > $signed(agg_ext)
                    : $signed(item_reg.sample_value) < $signed(agg_ext)))
                agg_ext = item_reg.sample_value;
            agg_he = 1'b1;
        end
    end

    function automatic logic [63:0] old_value();
        return store_ready_reg ? rd_reg : tea_pkg::start_value(cfg.kind);
    endfunction

    function automatic logic [63:0] result_reg_next_value();
        if (is_ext)
            return tea_pkg::pick_extreme(cfg.kind, old_value(),
                {{16{item_reg.sample_value[31]}}, item_reg.sample_value, 16'd0});
        return tea_pkg::addsat_signed(old_value(), acc_reg);
    endfunction

    function automatic logic [63:0] agg_next();
        if (is_ext)
            return agg_he
                ? tea_pkg::pick_extreme(cfg.kind, old_value(),
                    {{16{agg_ext[31]}}, agg_ext, 16'd0})
                : old_value();
        return tea_pkg::addsat_signed(old_value(), agg_sum[63:0]);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
            rd_reg <= store_mem[rd_addr];
        if (cmd.finish && item_reg.command == tea_pkg::CMD_SAMPLE)
        begin
            if (!cfg.scope && item_reg.in_region && slot_ok)
                store_mem[entry_cursor_reg[AW-1:0]] <= result_reg_next_value();
            else if (cfg.scope && item_reg.last_in_step)
                store_mem[0] <= agg_next();
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.mul_a)
        begin
            e_reg     <= (!diff[32] && diff != 33'd0) ? diff[31:0] : 32'd0;
            above_reg <= v_gt || (cfg.inclusive && v_eq);
            below_reg <= (!v_gt && !v_eq) || (cfg.inclusive && v_eq);
        end
        if (cmd.mul_b)
        begin
            unique case (cfg.kind)
                tea_pkg::KIND_ABOVE:  acc_reg <= above_reg ? {16'd0, item_reg.time_step, 16'd0} : '0;
                tea_pkg::KIND_BELOW:  acc_reg <= below_reg ? {16'd0, item_reg.time_step, 16'd0} : '0;
                tea_pkg::KIND_EXCESS: acc_reg <= tea_pkg::mulq({16'd0, e_reg, 16'd0}, item_reg.time_step);
                tea_pkg::KIND_SQUARE: acc_reg <= tea_pkg::mulq({16'd0, e_reg, 16'd0}, e_reg);
                default:              acc_reg <= '0;
            endcase
        end
        if (cmd.mul_c)
        begin
            if (cfg.kind == tea_pkg::KIND_SQUARE)
                acc_reg <= tea_pkg::mulq(acc_reg, item_reg.time_step);
        end
        if (cmd.mul_d)
        begin
            if (cfg.scope)
                acc_reg <= tea_pkg::mulq(acc_reg, item_reg.sample_weight);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            entry_cursor_reg <= '0;
            store_ready_reg  <= 1'b0;
            have_extreme_reg <= 1'b0;
            mismatch_reg     <= 1'b0;
            step_sum_reg     <= '0;
            elapsed_reg      <= '0;
            step_extreme_reg <= '0;
            step_counter_reg <= '0;
            tally_reg        <= '0;
            result_reg       <= '0;
        end
        else if (cmd.finish)
        begin
            if (item_reg.command == tea_pkg::CMD_CLEAR)
            begin
                entry_count_reg  <= '0;
                entry_cursor_reg <= '0;
                store_ready_reg  <= 1'b0;
                have_extreme_reg <= 1'b0;
                mismatch_reg     <= 1'b0;
                step_sum_reg     <= '0;
                elapsed_reg      <= '0;
                step_extreme_reg <= '0;
                step_counter_reg <= '0;
                tally_reg        <= '0;
                result_reg       <= '0;
            end
            else
            begin
                logic [15:0]   t;
                logic          mm;
                logic [CW-1:0] cur;
                logic          he;
                logic [31:0]   ext;
                logic [64:0]   ss;
                logic [64:0]   el;
                logic [31:0]   sc;
                tea_pkg::out_item_t r;
                t   = tally_reg;
                mm  = mismatch_reg;
                cur = entry_cursor_reg;
                he  = have_extreme_reg;
                ext = step_extreme_reg;
                ss  = {1'b0, step_sum_reg};
                r   = '0;
                if (item_reg.in_region)
                begin
                    if (t != 16'hFFFF)
                        t = t + 16'd1;
                    if (!cfg.scope)
                    begin
                        if (slot_ok)
                        begin
                            r.entry_index = 10'(entry_cursor_reg);
                            r.entry_value = result_reg_next_value();
                            cur = entry_cursor_reg + CW'(1);
                        end
                        else
                            mm = 1'b1;
                    end
                    else if (is_ext)
                    begin
                        if (!he || (cfg.kind == tea_pkg::KIND_MAX
                                ? $signed(item_reg.sample_value) > $signed(ext)
                                : $signed(item_reg.sample_value) < $signed(ext)))
                            ext = item_reg.sample_value;
                        he = 1'b1;
                    end
                    else
                    begin
                        ss = {1'b0, step_sum_reg} + {1'b0, wacc};
                        if (ss[64])
                            ss = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
                    end
                end
                if (cfg.scope)
                    r.entry_value = old_value();
                el = {1'b0, elapsed_reg};
                sc = step_counter_reg;
                if (item_reg.last_in_step)
                begin
                    if (!cfg.scope)
                    begin
                        r.updated_count = 11'(cur);
                        if (!store_ready_reg)
                        begin
                            entry_count_reg <= cur;
                            store_ready_reg <= 1'b1;
                        end
                        else if (cur != entry_count_reg)
                            mm = 1'b1;
                    end
                    else
                    begin
                        if (is_ext)
                        begin
                            r.entry_value = he
                                ? tea_pkg::pick_extreme(cfg.kind, old_value(),
                                    {{16{ext[31]}}, ext, 16'd0})
                                : old_value();
                            r.updated_count = he ? 11'd1 : 11'd0;
                        end
                        else
                        begin
                            r.entry_value   = tea_pkg::addsat_signed(old_value(), ss[63:0]);
                            r.updated_count = 11'd1;
                        end
                        if (!store_ready_reg)
                        begin
                            entry_count_reg <= CW'(1);
                            store_ready_reg <= 1'b1;
                        end
                        else if (entry_count_reg != CW'(1))
                            mm = 1'b1;
                    end
                    el = {1'b0, elapsed_reg} + {17'd0, item_reg.time_step, 16'd0};
                    if (el[64])
                        el = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
                    sc = step_counter_reg + 32'd1;
                end
                r.selected_count = t;
                r.step_done      = item_reg.last_in_step;
                r.step_total     = sc;
                r.elapsed_total  = el[63:0];
                r.count_error    = mm;
                result_reg       <= r;
                elapsed_reg      <= el[63:0];
                step_counter_reg <= sc;
                if (item_reg.last_in_step)
                begin
                    entry_cursor_reg <= '0;
                    step_sum_reg     <= '0;
                    step_extreme_reg <= '0;
                    have_extreme_reg <= 1'b0;
                    tally_reg        <= '0;
                    mismatch_reg     <= 1'b0;
                end
                else
                begin
                    entry_cursor_reg <= cur;
                    step_sum_reg     <= ss[63:0];
                    step_extreme_reg <= ext;
                    have_extreme_reg <= he;
                    tally_reg        <= t;
                    mismatch_reg     <= mm;
                end
            end
        end
    end
endmodule
`default_nettype wire
